// File: rtl/core/bsmcc_pkg.sv
// Shared constants and types for the battery sample median and coulomb counter.
`default_nettype none
package bsmcc_pkg;
  localparam int Ports = 4;
  localparam int Window = 5;
  localparam int PortW = 2;
  localparam int SlotW = 3;
  localparam int WinW = 20;            // Ports * Window
  localparam int WinIdxW = 5;
  localparam logic [3:0] CountMax = 4'd15;

  localparam logic [1:0] RegMinV = 2'd0;
  localparam logic [1:0] RegMaxV = 2'd1;
  localparam logic [1:0] RegMaxI = 2'd2;
  localparam logic [1:0] RegLimit = 2'd3;

  localparam logic [1:0] StUpdated = 2'd0;
  localparam logic [1:0] StRejected = 2'd1;
  localparam logic [1:0] StLatched = 2'd2;

  typedef struct packed {
    logic        load;      // take input request, check it
    logic        write_win; // store sample in ring
    logic        clear_rank;
    logic        rank_step; // compare one ring entry against all
    logic        mul_pow;
    logic        mul_chg;
    logic        mul_eng;
    logic        accum;
    logic        finish;
  } bsmcc_cmd_t;

  typedef struct packed {
    logic       out_range;
    logic       valid_smp;
    logic       rank_last;
  } bsmcc_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/bsmcc_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
`default_nettype none
interface bsmcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  port;
  logic [15:0] voltage_mv;
  logic signed [15:0] current_ma;
  logic [15:0] elapsed_ms;
  modport source (output valid, port, voltage_mv, current_ma, elapsed_ms, input ready);
  modport sink (input valid, port, voltage_mv, current_ma, elapsed_ms, output ready);
endinterface

interface bsmcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  port_out;
  logic [1:0]  status;
  logic [15:0] median_voltage_mv;
  logic signed [15:0] median_current_ma;
  logic signed [31:0] power_uw;
  logic signed [63:0] charge_mams;
  logic signed [63:0] energy_uwms;
  logic [3:0]  invalid_count;
  modport source (output valid, port_out, status, median_voltage_mv, median_current_ma,
                  power_uw, charge_mams, energy_uwms, invalid_count, input ready);
  modport sink (input valid, port_out, status, median_voltage_mv, median_current_ma,
                power_uw, charge_mams, energy_uwms, invalid_count, output ready);
endinterface

interface bsmcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bsmcc_ctrl.sv
// Sequencer: steps one request through check, ring update, median, products.
`default_nettype none
module bsmcc_ctrl
  import bsmcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        out_busy,
  output logic             out_load,
  output bsmcc_cmd_t       cmd,
  input  bsmcc_stat_t      stat
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RANK, S_POW, S_CHG, S_ENG, S_ACC, S_DONE
  } state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && !out_busy;

  always_comb begin
    cmd = '0;
    cmd.load = in_ready && in_valid;
    unique case (state)
      S_CHECK: begin
        cmd.write_win = stat.valid_smp;
        cmd.clear_rank = 1'b1;
      end
      S_RANK: cmd.rank_step = 1'b1;
      S_POW: cmd.mul_pow = 1'b1;
      S_CHG: cmd.mul_chg = 1'b1;
      S_ENG: cmd.mul_eng = 1'b1;
      S_ACC: cmd.accum = 1'b1;
      S_DONE: cmd.finish = out_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: state <= stat.out_range ? S_DONE : S_RANK;
        S_RANK: if (stat.rank_last) state <= S_POW;
        S_POW: state <= S_CHG;
        S_CHG: state <= S_ENG;
        S_ENG: state <= S_ACC;
        S_ACC: state <= S_DONE;
        S_DONE: if (!out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/bsmcc_dp.sv
// Datapath: per-port rings, rank-count median, multipliers and totals.
`default_nettype none
module bsmcc_dp
  import bsmcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  bsmcc_cmd_t       cmd,
  output bsmcc_stat_t      stat,
  input  wire logic [1:0]  in_port,
  input  wire logic [15:0] in_mv,
  input  wire logic [15:0] in_ma,
  input  wire logic [15:0] in_dt,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic [1:0]       r_port,
  output logic [1:0]       r_status,
  output logic [15:0]      r_mv,
  output logic [15:0]      r_ma,
  output logic [31:0]      r_pow,
  output logic [63:0]      r_chg,
  output logic [63:0]      r_eng,
  output logic [3:0]       r_cnt
);
  logic [15:0] min_v, max_v;
  logic [14:0] max_i;
  logic [3:0]  limit;

  logic [15:0] vwin [WinW];
  logic [15:0] iwin [WinW];
  logic [SlotW-1:0] wslot [Ports];
  logic [3:0]  bad [Ports];
  logic        lat [Ports];
  logic [63:0] chg_tot [Ports];
  logic [63:0] eng_tot [Ports];

  logic [1:0]  port;
  logic [15:0] mv, ma, dt;
  logic        oor, lat_q, ok;
  logic [SlotW-1:0] rk;
  logic [15:0] vmed, imed;
  logic [31:0] pow;
  logic [47:0] chg_p;
  logic [63:0] eng_p;
  logic [3:0]  cnt;

  logic [PortW-1:0] pi;
  logic [15:0] mag;
  logic        in_ok;
  logic [3:0]  bad_inc;
  logic [WinIdxW-1:0] base;
  logic [SlotW-1:0] slot_eff;
  logic [15:0] cv, ci;
  logic [SlotW-1:0] lt_v, le_v, lt_i, le_i;

  assign pi = in_port;
  assign mag = in_ma[15] ? 16'(-in_ma) : in_ma;
  assign in_ok = (in_mv >= min_v) && (in_mv <= max_v) && (mag <= {1'b0, max_i});
  assign bad_inc = (bad[pi] < CountMax) ? bad[pi] + 4'd1 : bad[pi];
  assign base = WinIdxW'(port) * WinIdxW'(Window);
  assign slot_eff = (wslot[port] >= SlotW'(Window)) ? '0 : wslot[port];
  assign cv = vwin[base + WinIdxW'(rk)];
  assign ci = iwin[base + WinIdxW'(rk)];

  // count entries below / at-or-below the candidate; it is the median when
  // fewer than half+1 lie below and at least half+1 lie at or below
  always_comb begin
    lt_v = '0; le_v = '0; lt_i = '0; le_i = '0;
    for (int k = 0; k < Window; k++) begin
      if (vwin[base + WinIdxW'(k)] < cv) lt_v = lt_v + 1'b1;
      if (vwin[base + WinIdxW'(k)] <= cv) le_v = le_v + 1'b1;
      if ($signed(iwin[base + WinIdxW'(k)]) < $signed(ci)) lt_i = lt_i + 1'b1;
      if ($signed(iwin[base + WinIdxW'(k)]) <= $signed(ci)) le_i = le_i + 1'b1;
    end
  end

  // a latched port still runs the median so its result carries current values
  assign stat.out_range = oor;
  assign stat.valid_smp = ok;
  assign stat.rank_last = (rk == SlotW'(Window - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      min_v <= '0;
      max_v <= 16'd36000;
      max_i <= 15'd3200;
      limit <= 4'd10;
      for (int p = 0; p < Ports; p++) begin
        wslot[p] <= '0; bad[p] <= '0; lat[p] <= 1'b0;
        chg_tot[p] <= '0; eng_tot[p] <= '0;
      end
      for (int k = 0; k < WinW; k++) begin
        vwin[k] <= '0; iwin[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegMinV: min_v <= cfg_data;
          RegMaxV: max_v <= cfg_data;
          RegMaxI: max_i <= cfg_data[14:0];
          RegLimit: limit <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        port <= in_port; mv <= in_mv; ma <= in_ma; dt <= in_dt;
        oor <= 1'b0;
        lat_q <= lat[pi];
        ok <= in_ok && !lat[pi];
        cnt <= bad[pi];
        if (!lat[pi]) begin
          if (in_ok) begin
            bad[pi] <= '0;
            cnt <= '0;
          end else begin
            bad[pi] <= bad_inc;
            cnt <= bad_inc;
            if (bad_inc > limit) lat[pi] <= 1'b1;
          end
        end
      end
      if (cmd.write_win) begin
        vwin[base + WinIdxW'(slot_eff)] <= mv;
        iwin[base + WinIdxW'(slot_eff)] <= ma;
        wslot[port] <= (slot_eff + 1'b1 >= SlotW'(Window)) ? '0 : slot_eff + 1'b1;
      end
      if (cmd.clear_rank) rk <= '0;
      if (cmd.rank_step) begin
        if (lt_v <= SlotW'(Window / 2) && le_v > SlotW'(Window / 2)) vmed <= cv;
        if (lt_i <= SlotW'(Window / 2) && le_i > SlotW'(Window / 2)) imed <= ci;
        if (!stat.rank_last) rk <= rk + 1'b1;
      end
      if (cmd.mul_pow) pow <= 32'($signed({1'b0, vmed}) * $signed(imed));
      if (cmd.mul_chg) chg_p <= 48'($signed(imed) * $signed({1'b0, dt}));
      if (cmd.mul_eng) eng_p <= 64'($signed(pow) * $signed({1'b0, dt}));
      if (cmd.accum && ok && dt != '0) begin
        chg_tot[port] <= chg_tot[port] + {{16{chg_p[47]}}, chg_p};
        eng_tot[port] <= eng_tot[port] + eng_p;
      end
      if (cmd.finish) begin
        r_port <= port;
        r_status <= lat_q ? StLatched : (ok ? StUpdated : StRejected);
        r_mv <= vmed; r_ma <= imed; r_pow <= pow;
        r_chg <= chg_tot[port]; r_eng <= eng_tot[port];
        r_cnt <= cnt;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/battery_sample_median_and_coulomb_count.sv
// A request passes a check, 5 median rank steps of the shared compare unit,
// three registered multiplies and an accumulate before its result is loaded.
// The sequencer takes one request at a time.
// Next request is accepted once the result is loaded; a result still waiting
// in the output register holds the sequencer in its last state.
// Synchronous active-high reset: rings, totals, counts zeroed, registers to defaults.
`default_nettype none
module battery_sample_median_and_coulomb_count
  import bsmcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  bsmcc_in_if.sink   in_ch,
  bsmcc_out_if.source out_ch,
  bsmcc_cfg_if.sink  cfg
);
  bsmcc_cmd_t  cmd;
  bsmcc_stat_t stat;
  logic out_load, ovalid;
  logic [15:0] r_ma;
  logic [31:0] r_pow;
  logic [63:0] r_chg, r_eng;

  assign cfg.ready = 1'b1;
  assign out_ch.valid = ovalid;
  assign out_ch.median_current_ma = $signed(r_ma);
  assign out_ch.power_uw = $signed(r_pow);
  assign out_ch.charge_mams = $signed(r_chg);
  assign out_ch.energy_uwms = $signed(r_eng);

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (out_load) ovalid <= 1'b1;
    else if (out_ch.ready) ovalid <= 1'b0;
  end

  bsmcc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(ovalid && !out_ch.ready),
    .out_load, .cmd, .stat
  );

  bsmcc_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .in_port(in_ch.port), .in_mv(in_ch.voltage_mv),
    .in_ma(in_ch.current_ma), .in_dt(in_ch.elapsed_ms),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .r_port(out_ch.port_out), .r_status(out_ch.status),
    .r_mv(out_ch.median_voltage_mv), .r_ma, .r_pow, .r_chg, .r_eng,
    .r_cnt(out_ch.invalid_count)
  );
endmodule
`default_nettype wire

// File: tb/bsmcc_tb_pkg.sv
// Sample predictor and result scoreboard class for the battery sample block.
`timescale 1ns / 100ps
package bsmcc_tb_pkg;
  import bsmcc_pkg::*;

  typedef struct packed {
    logic [1:0]         port;
    logic [15:0]        voltage_mv;
    logic signed [15:0] current_ma;
    logic [15:0]        elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic [1:0]         port_out;
    logic [1:0]         status;
    logic [15:0]        median_voltage_mv;
    logic signed [15:0] median_current_ma;
    logic signed [31:0] power_uw;
    logic signed [63:0] charge_mams;
    logic signed [63:0] energy_uwms;
    logic [3:0]         invalid_count;
  } reading_t;

  class battery_scoreboard;
    logic [15:0] min_mv, max_mv;
    logic [14:0] max_ma;
    logic [3:0]  limit;
    logic [15:0] vring[Ports][Window];
    logic signed [15:0] iring[Ports][Window];
    int unsigned slot[Ports];
    logic [3:0]  bad[Ports];
    bit          latched[Ports];
    logic [63:0] charge[Ports], energy[Ports];
    reading_t    pending[$];
    int          mismatches;
    int          checked;
    int          n_rejected, n_latched;

    function new();
      min_mv = 16'd0;
      max_mv = 16'd36000;
      max_ma = 15'd3200;
      limit = 4'd10;
      mismatches = 0;
      checked = 0;
      n_rejected = 0;
      n_latched = 0;
      for (int p = 0; p < Ports; p++) begin
        for (int k = 0; k < Window; k++) begin
          vring[p][k] = '0;
          iring[p][k] = '0;
        end
        slot[p] = 0;
        bad[p] = '0;
        latched[p] = 0;
        charge[p] = '0;
        energy[p] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        RegMinV: min_mv = val;
        RegMaxV: max_mv = val;
        RegMaxI: max_ma = val[14:0];
        RegLimit: limit = val[3:0];
        default: ;
      endcase
    endfunction

    // median as the middle element of the sorted ring
    function logic [15:0] mid_voltage(int p);
      logic [15:0] s[Window];
      logic [15:0] t;
      for (int k = 0; k < Window; k++) s[k] = vring[p][k];
      for (int a = 0; a < Window; a++)
        for (int b = 0; b < Window - 1 - a; b++)
          if (s[b] > s[b+1]) begin
            t = s[b]; s[b] = s[b+1]; s[b+1] = t;
          end
      return s[Window/2];
    endfunction

    function logic signed [15:0] mid_current(int p);
      logic signed [15:0] s[Window];
      logic signed [15:0] t;
      for (int k = 0; k < Window; k++) s[k] = iring[p][k];
      for (int a = 0; a < Window; a++)
        for (int b = 0; b < Window - 1 - a; b++)
          if (s[b] > s[b+1]) begin
            t = s[b]; s[b] = s[b+1]; s[b+1] = t;
          end
      return s[Window/2];
    endfunction

    function void note_sample(sample_t smp);
      reading_t r;
      int p;
      logic [16:0] mag;
      logic signed [63:0] pw;
      logic [15:0] vm;
      logic signed [15:0] cm;
      p = smp.port;
      r = '0;
      r.port_out = smp.port;
      if (p >= Ports) begin
        r.status = StRejected;
        pending.push_back(r);
        return;
      end
      if (latched[p]) begin
        r.status = StLatched;
        n_latched++;
      end else begin
        mag = smp.current_ma < 0 ? 17'(-$signed({smp.current_ma[15], smp.current_ma}))
                                 : 17'(smp.current_ma);
        if (smp.voltage_mv < min_mv || smp.voltage_mv > max_mv || mag > {2'b0, max_ma}) begin
          if (bad[p] < CountMax) bad[p]++;
          if (bad[p] > limit) latched[p] = 1;
          r.status = StRejected;
          n_rejected++;
        end else begin
          bad[p] = '0;
          vring[p][slot[p]] = smp.voltage_mv;
          iring[p][slot[p]] = smp.current_ma;
          slot[p] = (slot[p] + 1 >= Window) ? 0 : slot[p] + 1;
          r.status = StUpdated;
          vm = mid_voltage(p);
          cm = mid_current(p);
          pw = $signed({48'b0, vm}) * 64'(cm);
          charge[p] += 64'(cm) * $signed({48'b0, smp.elapsed_ms});
          energy[p] += pw * $signed({48'b0, smp.elapsed_ms});
        end
      end
      vm = mid_voltage(p);
      cm = mid_current(p);
      pw = $signed({48'b0, vm}) * 64'(cm);
      r.median_voltage_mv = vm;
      r.median_current_ma = cm;
      r.power_uw = pw[31:0];
      r.charge_mams = charge[p];
      r.energy_uwms = energy[p];
      r.invalid_count = bad[p];
      pending.push_back(r);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.port_out !== want.port_out || got.status !== want.status ||
          got.median_voltage_mv !== want.median_voltage_mv ||
          got.median_current_ma !== want.median_current_ma ||
          got.power_uw !== want.power_uw || got.charge_mams !== want.charge_mams ||
          got.energy_uwms !== want.energy_uwms ||
          got.invalid_count !== want.invalid_count) begin
        $display("%0t: result mismatch\n  expected %p\n  actual   %p", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass
endpackage

// File: tb/battery_sample_median_and_coulomb_count_tb.sv
// Top-level testbench: drives samples and register writes, checks every result.
`timescale 1ns / 100ps
module battery_sample_median_and_coulomb_count_tb;
  import bsmcc_pkg::*;
  import bsmcc_tb_pkg::*;

  logic clk;
  logic rst;
  int   send_idle, take_idle;
  int   cycles;
  int   n_sent;
  battery_scoreboard sb;

  bsmcc_in_if  in_ch();
  bsmcc_out_if out_ch();
  bsmcc_cfg_if cfg();

  battery_sample_median_and_coulomb_count dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    in_ch.valid = 0;
    in_ch.port = '0;
    in_ch.voltage_mv = '0;
    in_ch.current_ma = '0;
    in_ch.elapsed_ms = '0;
    out_ch.ready = 0;
    cfg.valid = 0;
    cfg.index = '0;
    cfg.data = '0;
  end

  // result side: random stalls, check on every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_reading({out_ch.port_out, out_ch.status, out_ch.median_voltage_mv,
                          out_ch.median_current_ma, out_ch.power_uw, out_ch.charge_mams,
                          out_ch.energy_uwms, out_ch.invalid_count});
      out_ch.ready <= ($urandom_range(99) >= take_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // valid stays high between back-to-back requests; it drops on idle or settle
  task automatic send_sample(sample_t smp);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.port <= smp.port;
    in_ch.voltage_mv <= smp.voltage_mv;
    in_ch.current_ma <= smp.current_ma;
    in_ch.elapsed_ms <= smp.elapsed_ms;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(smp);
    n_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    sb.set_reg(idx, val);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic sample(int p, int mv, int ma, int ms);
    sample_t s;
    s.port = 2'(p);
    s.voltage_mv = 16'(mv);
    s.current_ma = 16'(ma);
    s.elapsed_ms = 16'(ms);
    send_sample(s);
  endtask

  // mostly in-window readings, some out of range, across all ports
  task automatic random_burst(int n);
    sample_t s;
    for (int k = 0; k < n; k++) begin
      s.port = 2'($urandom_range(3));
      s.elapsed_ms = ($urandom_range(9) == 0) ? 16'd0
                   : ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
      if ($urandom_range(9) < 8) begin
        s.voltage_mv = 16'($urandom_range(sb.max_mv, sb.min_mv));
        s.current_ma = 16'($signed($urandom_range(2 * sb.max_ma))
                           - $signed({17'b0, sb.max_ma}));
      end else begin
        s.voltage_mv = 16'($urandom_range(40000));
        s.current_ma = 16'($urandom);
        if ($urandom_range(3) == 0) s.voltage_mv = 16'($urandom);
      end
      send_sample(s);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    n_sent = 0;
    send_idle = 25;
    take_idle = 77;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero elapsed, most negative current, saturation
    sample(0, 12000, 1500, 100);
    sample(0, 0, 0, 0);
    sample(0, 36000, 3200, 65535);
    sample(0, 36000, -3200, 1);
    sample(0, 36001, 0, 10);
    sample(0, 1000, -32768, 10);
    sample(1, 65535, 32767, 65535);
    sample(0, 20000, 3201, 10);
    sample(0, 20000, -3201, 10);
    sample(2, 30000, -2000, 500);
    sample(2, 30000, -1000, 0);
    for (int k = 0; k < 11; k++) sample(3, 50000, 0, 5);
    sample(3, 12000, 100, 100);
    sample(3, 12000, 100, 100);
    settle();

    write_reg(RegMinV, 16'd40000);
    write_reg(RegMaxV, 16'd40000);
    write_reg(RegMaxI, 16'd32767);
    write_reg(RegLimit, 16'd15);
    sample(1, 40000, 32767, 65535);
    sample(1, 40000, -32767, 65535);
    for (int k = 0; k < 17; k++) sample(1, 39999, 0, 1);
    settle();

    write_reg(RegMinV, 16'd0);
    write_reg(RegMaxV, 16'd0);
    write_reg(RegMaxI, 16'd0);
    write_reg(RegLimit, 16'd0);
    sample(2, 0, 0, 7);
    sample(2, 1, 0, 7);
    sample(2, 0, 0, 7);
    settle();

    // random phases under three idling schemes
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 77; take_idle = 25; end
      if (ph == 4) begin send_idle = 0; take_idle = 0; end
      write_reg(RegMinV, 16'($urandom_range(15000)));
      write_reg(RegMaxV, 16'($urandom_range(40000, 25000)));
      write_reg(RegMaxI, 16'($urandom_range(32767)));
      write_reg(RegLimit, 16'($urandom_range(15)));
      random_burst(245);
      settle();
    end

    $display("%0d samples sent, %0d results checked (%0d rejected, %0d on latched ports)",
             n_sent, sb.checked, sb.n_rejected, sb.n_latched);
    $display("register settings swept including both range extremes");
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: battery_sample_median_and_coulomb_count.f
rtl/core/bsmcc_pkg.sv
rtl/core/bsmcc_if.sv
rtl/core/bsmcc_ctrl.sv
rtl/core/bsmcc_dp.sv
rtl/core/battery_sample_median_and_coulomb_count.sv
tb/bsmcc_tb_pkg.sv
tb/battery_sample_median_and_coulomb_count_tb.sv
